// ===== hw/rtl/sse_pkg.sv =====
// shared types and constants of the sample statistics engine
`default_nettype none

package sse_pkg;

  localparam int unsigned SampleBitsDef  = 16;
  localparam int unsigned CountBitsDef   = 16;
  localparam int unsigned SampleCountRst = 10000;
  localparam int unsigned OutBits        = 16;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_LOAD,
    ST_DIV_SUM,
    ST_DIV_SQ,
    ST_MUL,
    ST_VAR,
    ST_SQRT,
    ST_OUT
  } sse_state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/sample_statistics_engine_core.sv =====
// sample statistics engine: running min, max, mean and standard deviation
`default_nettype none

// channel   direction  handshake                  payload
// --------  ---------  -------------------------  ----------------------------------------
// cfg       in         cfg_we_i (no wait)         cfg_wdata_i = run length
// sample    in         in_valid_i / in_ready_o    sample_i
// result    out        out_valid_o / out_ready_i  min_value_o max_value_o mean_value_o
//                                                 std_dev_o
//
// samples are taken one per cycle while accumulating; the sample that closes a run
// starts the closing math, during which in_ready_o is low. the math runs on the one
// shared subtractor: restoring division of the sum and of the sum of squares one
// quotient bit per cycle, then a digit-by-digit square root one root bit per cycle.
// a result waits in the output register; the next run accumulates meanwhile and only
// its own closing stalls if the previous result is still not taken.
// reset (asynchronous, active low) clears the accumulators and loads the default run
// length; there is no clearing pass.

module sample_statistics_engine_core
  import sse_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SampleBitsDef,
  parameter int unsigned COUNT_BITS  = CountBitsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration
  input  wire logic                cfg_we_i,
  input  wire logic [15:0]         cfg_wdata_i,
  // sample items
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [15:0]         sample_i,
  // result items
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [OutBits-1:0]       min_value_o,
  output logic [OutBits-1:0]       max_value_o,
  output logic [OutBits-1:0]       mean_value_o,
  output logic [OutBits-1:0]       std_dev_o
);

  localparam int unsigned S     = SAMPLE_BITS;
  localparam int unsigned C     = COUNT_BITS;
  // sum and sum of squares are wide enough that they never overflow
  localparam int unsigned SumW  = S + C;
  localparam int unsigned SqW   = 2 * S + C;
  // shared subtractor covers the divider remainder, the variance and the root remainder
  localparam int unsigned AluW  = (2 * S + 1 > C + 1) ? 2 * S + 1 : C + 1;
  localparam int unsigned CntW  = $clog2(SqW);

  sse_state_e state_q, state_d;

  // configuration and accumulators
  logic [C-1:0]    len_q, len_d;
  logic [S-1:0]    min_q, min_d;
  logic [S-1:0]    max_q, max_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic [SqW-1:0]  sumsq_q, sumsq_d;
  logic [C-1:0]    taken_q, taken_d;
  logic            sqv_q, sqv_d;      // a square waits to be added
  logic [2*S-1:0]  sq_q, sq_d;

  // closing math
  logic [SqW-1:0]  dvd_q, dvd_d;      // dividend in, quotient out
  logic [C-1:0]    drem_q, drem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [S-1:0]    mean_q, mean_d;
  logic [2*S-1:0]  msq_q, msq_d;
  logic [2*S-1:0]  prod_q, prod_d;
  logic [2*S-1:0]  val_q, val_d;      // radicand, two bits leave per step
  logic [S:0]      srem_q, srem_d;
  logic [S-1:0]    root_q, root_d;

  // result register
  logic            out_valid_q, out_valid_d;
  logic [OutBits-1:0] min_out_q, min_out_d;
  logic [OutBits-1:0] max_out_q, max_out_d;
  logic [OutBits-1:0] mean_out_q, mean_out_d;
  logic [OutBits-1:0] std_out_q, std_out_d;

  logic            in_fire;
  logic            out_free;
  logic [S-1:0]    smp;
  logic [2*S-1:0]  smp_ext;
  logic [2*S-1:0]  mean_ext;
  logic [C-1:0]    len_eff;
  logic [C-1:0]    taken_inc;
  logic            run_done;

  logic [C:0]      div_sh;
  logic [S+2:0]    sqrt_sh;
  logic [S+1:0]    trial;
  logic [SqW-1:0]  dvd_nx;
  logic [AluW-1:0] alu_a, alu_b;
  logic [AluW:0]   alu_diff;
  logic            alu_lt;

  assign smp       = sample_i[S-1:0];
  assign smp_ext   = (2*S)'(smp);
  assign mean_ext  = (2*S)'(mean_q);
  // a run length of zero behaves as one
  assign len_eff   = (len_q == '0) ? C'(1) : len_q;
  assign taken_inc = taken_q + C'(1);
  assign in_fire   = in_valid_i && in_ready_o;
  // a lowered run length closes the run as soon as the count reaches or passes it
  assign run_done  = taken_inc >= len_eff;
  assign out_free  = !out_valid_q || out_ready_i;

  // divider and root step operands
  assign div_sh  = {drem_q, dvd_q[SqW-1]};
  assign sqrt_sh = {srem_q, val_q[2*S-1 -: 2]};
  assign trial   = {root_q, 2'b01};

  // shared subtract and compare unit
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    unique case (state_q)
      ST_DIV_SUM, ST_DIV_SQ: begin
        alu_a = AluW'(div_sh);
        alu_b = AluW'(taken_q);
      end
      ST_VAR: begin
        alu_a = AluW'(msq_q);
        alu_b = AluW'(prod_q);
      end
      ST_SQRT: begin
        alu_a = AluW'(sqrt_sh);
        alu_b = AluW'(trial);
      end
      default: begin
      end
    endcase
  end

  assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_lt   = alu_diff[AluW];
  assign dvd_nx   = {dvd_q[SqW-2:0], ~alu_lt};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_ACC: begin
        if (in_fire && run_done) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD:    state_d = ST_DIV_SUM;
      ST_DIV_SUM: begin
        if (cnt_q == '0) begin
          state_d = ST_DIV_SQ;
        end
      end
      ST_DIV_SQ: begin
        if (cnt_q == '0) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:     state_d = ST_VAR;
      ST_VAR:     state_d = ST_SQRT;
      ST_SQRT: begin
        if (cnt_q == '0) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_ACC;
        end
      end
      default:    state_d = ST_ACC;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready_o  = (state_q == ST_ACC);
    out_valid_o = out_valid_q;
  end

  assign min_value_o  = min_out_q;
  assign max_value_o  = max_out_q;
  assign mean_value_o = mean_out_q;
  assign std_dev_o    = std_out_q;

  // datapath
  always_comb begin
    len_d       = len_q;
    min_d       = min_q;
    max_d       = max_q;
    sum_d       = sum_q;
    sumsq_d     = sumsq_q;
    taken_d     = taken_q;
    dvd_d       = dvd_q;
    drem_d      = drem_q;
    cnt_d       = cnt_q;
    mean_d      = mean_q;
    msq_d       = msq_q;
    prod_d      = prod_q;
    val_d       = val_q;
    srem_d      = srem_q;
    root_d      = root_q;
    min_out_d   = min_out_q;
    max_out_d   = max_out_q;
    mean_out_d  = mean_out_q;
    std_out_d   = std_out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (cfg_we_i) begin
      len_d = cfg_wdata_i[C-1:0];
    end

    // the square of a sample is registered and added in the cycle after the sample
    sq_d  = smp_ext * smp_ext;
    sqv_d = in_fire;
    if (sqv_q) begin
      sumsq_d = sumsq_q + SqW'(sq_q);
    end

    unique case (state_q)
      ST_ACC: begin
        if (in_fire) begin
          if (smp < min_q) begin
            min_d = smp;
          end
          if (smp > max_q) begin
            max_d = smp;
          end
          sum_d   = sum_q + SumW'(smp);
          taken_d = taken_inc;
        end
      end
      ST_LOAD: begin
        dvd_d  = {sum_q, S'(0)};
        drem_d = '0;
        cnt_d  = CntW'(SumW - 1);
      end
      ST_DIV_SUM: begin
        dvd_d  = dvd_nx;
        drem_d = alu_lt ? div_sh[C-1:0] : alu_diff[C-1:0];
        cnt_d  = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          mean_d = dvd_nx[S-1:0];
          dvd_d  = sumsq_q;
          drem_d = '0;
          cnt_d  = CntW'(SqW - 1);
        end
      end
      ST_DIV_SQ: begin
        dvd_d  = dvd_nx;
        drem_d = alu_lt ? div_sh[C-1:0] : alu_diff[C-1:0];
        cnt_d  = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          msq_d = dvd_nx[2*S-1:0];
        end
      end
      ST_MUL: begin
        prod_d = mean_ext * mean_ext;
      end
      ST_VAR: begin
        // clamp at zero
        val_d  = alu_lt ? '0 : alu_diff[2*S-1:0];
        srem_d = '0;
        root_d = '0;
        cnt_d  = CntW'(S - 1);
      end
      ST_SQRT: begin
        val_d = {val_q[2*S-3:0], 2'b00};
        cnt_d = cnt_q - CntW'(1);
        if (alu_lt) begin
          srem_d = sqrt_sh[S:0];
          root_d = {root_q[S-2:0], 1'b0};
        end else begin
          srem_d = alu_diff[S:0];
          root_d = {root_q[S-2:0], 1'b1};
        end
      end
      ST_OUT: begin
        if (out_free) begin
          min_out_d   = OutBits'(min_q);
          max_out_d   = OutBits'(max_q);
          mean_out_d  = OutBits'(mean_q);
          std_out_d   = OutBits'(root_q);
          out_valid_d = 1'b1;
          // clear for the next run
          min_d       = '1;
          max_d       = '0;
          sum_d       = '0;
          sumsq_d     = '0;
          taken_d     = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // control and accumulator registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      len_q       <= C'(SampleCountRst);
      min_q       <= '1;
      max_q       <= '0;
      sum_q       <= '0;
      sumsq_q     <= '0;
      taken_q     <= '0;
      sqv_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      min_q       <= min_d;
      max_q       <= max_d;
      sum_q       <= sum_d;
      sumsq_q     <= sumsq_d;
      taken_q     <= taken_d;
      sqv_q       <= sqv_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sq_q       <= sq_d;
    dvd_q      <= dvd_d;
    drem_q     <= drem_d;
    mean_q     <= mean_d;
    msq_q      <= msq_d;
    prod_q     <= prod_d;
    val_q      <= val_d;
    srem_q     <= srem_d;
    root_q     <= root_d;
    min_out_q  <= min_out_d;
    max_out_q  <= max_out_d;
    mean_out_q <= mean_out_d;
    std_out_q  <= std_out_d;
  end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// testbench of the sample statistics engine: per-run min, max, mean and deviation checks
module testbench;
  import sse_pkg::*;

  // a clock-side ready pattern must never leave the block quiet this long
  localparam int unsigned STALL_LIMIT = 20000;
  // settling margin that covers a run still in flight
  localparam int unsigned SETTLE_CYCLES = 150;
  // long receiver hold-off, well past one closing so the input backs up
  localparam int unsigned HOLD_CYCLES = 1500;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned RANDOM_ITEMS = 1100;
  // items taken under the longest run length before it is lowered
  localparam int unsigned FULL_RUN_ITEMS = 150;

  typedef struct packed {
    logic [OutBits-1:0] min_value;
    logic [OutBits-1:0] max_value;
    logic [OutBits-1:0] mean_value;
    logic [OutBits-1:0] std_dev;
  } run_stats_t;

  // kinds of random latency values
  typedef enum int {
    SHAPE_FULL,
    SHAPE_LOW,
    SHAPE_HIGH,
    SHAPE_EDGE,
    SHAPE_REPEAT
  } sample_shape_e;

  // dut ports; the inputs are at known values from time zero
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [15:0]        cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [15:0]        sample_i    = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [OutBits-1:0] min_value_o;
  logic [OutBits-1:0] max_value_o;
  logic [OutBits-1:0] mean_value_o;
  logic [OutBits-1:0] std_dev_o;

  // predicted run state, mirrors what the block accumulates
  logic [15:0] run_len    = 16'(SampleCountRst);
  logic [15:0] acc_min    = 16'hFFFF;
  logic [15:0] acc_max    = '0;
  logic [31:0] acc_sum    = '0;
  logic [47:0] acc_sum_sq = '0;
  logic [15:0] acc_taken  = '0;

  // statistics predicted but not yet seen on the result port, oldest first
  run_stats_t  pending_stats[$];

  int unsigned fail_count   = 0;
  int unsigned sent_count   = 0;
  int unsigned burst_left   = 0;
  int unsigned quiet_cycles = 0;
  logic [15:0] last_value   = '0;

  // sender and receiver behavior, switched by the tests
  bit          tx_gaps_en  = 1'b1;
  bit          rx_stall_en = 1'b1;
  int unsigned hold_req    = 0;
  int unsigned hold_seen   = 0;
  int unsigned hold_left   = 0;
  int unsigned phase_left  = 0;

  sample_statistics_engine_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .min_value_o (min_value_o),
    .max_value_o (max_value_o),
    .mean_value_o(mean_value_o),
    .std_dev_o   (std_dev_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // floor of the square root, found by trying each root bit from the top
  function automatic logic [15:0] floor_sqrt(input logic [63:0] x);
    logic [15:0] root;
    logic [15:0] trial;
    root = '0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (16'd1 << b);
      if (64'(trial) * 64'(trial) <= x) root = trial;
    end
    return root;
  endfunction

  // fold one latency into the run; returns 1 with the statistics when the run closes
  function automatic bit fold_sample(input logic [15:0] value, output run_stats_t stats);
    logic [15:0] limit;
    logic [63:0] mean;
    logic [63:0] mean_sq;
    logic [63:0] variance;
    stats = '0;
    // a zero run length behaves as a run of one
    limit = (run_len == '0) ? 16'd1 : run_len;
    if (value < acc_min) acc_min = value;
    if (value > acc_max) acc_max = value;
    acc_sum    = acc_sum + 32'(value);
    acc_sum_sq = acc_sum_sq + 48'(value) * 48'(value);
    acc_taken  = acc_taken + 16'd1;
    // a length lowered mid-run closes as soon as the count reaches or passes it
    if (acc_taken < limit) return 1'b0;
    mean     = 64'(acc_sum) / 64'(acc_taken);
    mean_sq  = 64'(acc_sum_sq) / 64'(acc_taken);
    variance = (mean_sq >= mean * mean) ? mean_sq - mean * mean : 64'd0;
    stats.min_value  = acc_min;
    stats.max_value  = acc_max;
    stats.mean_value = mean[15:0];
    stats.std_dev    = floor_sqrt(variance);
    acc_min    = 16'hFFFF;
    acc_max    = '0;
    acc_sum    = '0;
    acc_sum_sq = '0;
    acc_taken  = '0;
    return 1'b1;
  endfunction

  function automatic logic [15:0] random_latency();
    sample_shape_e shape;
    logic [15:0]   value;
    shape = sample_shape_e'($urandom_range(SHAPE_FULL, SHAPE_REPEAT));
    case (shape)
      SHAPE_FULL:   value = 16'($urandom);
      SHAPE_LOW:    value = 16'($urandom_range(0, 15));
      SHAPE_HIGH:   value = 16'($urandom_range(16'hFFF0, 16'hFFFF));
      SHAPE_EDGE:   value = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default:      value = last_value;
    endcase
    last_value = value;
    return value;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_REPORTS) $display("mismatch: %s", msg);
    fail_count++;
  endtask

  // offer one latency item; valid stays up across back-to-back items within a burst
  task automatic send_sample(input logic [15:0] value);
    run_stats_t stats;
    if (tx_gaps_en && burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i <= 1'b1;
    sample_i   <= value;
    do @(posedge clk_i); while (!in_ready_o);
    if (fold_sample(value, stats)) pending_stats.push_back(stats);
    if (burst_left != 0) burst_left--;
    sent_count++;
  endtask

  // stop sending and wait until every predicted result has come out
  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // run length is only changed with the block idle
  task automatic write_run_length(input logic [15:0] len);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    run_len = len;
  endtask

  // the reset length is in force, then it is lowered below the samples already taken
  task automatic test_default_run_length();
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h0001);
    send_sample(16'h8000);
    write_run_length(16'd2);
    send_sample(16'h7FFF);
  endtask

  // zero length: every item closes a run of one, deviation zero
  task automatic test_zero_run_length();
    write_run_length(16'd0);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h0001);
    send_sample(16'hAAAA);
    send_sample(16'h5555);
  endtask

  task automatic test_unit_run_length();
    write_run_length(16'd1);
    send_sample(16'h1234);
    send_sample(16'hFEDC);
  endtask

  // widest spread and all-max runs, largest sqrt operand and largest mean
  task automatic test_extreme_samples();
    write_run_length(16'd4);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    repeat (4) send_sample(16'hFFFF);
  endtask

  // longest run length with mostly max samples, then closed by a lowered length
  task automatic test_full_length_run();
    write_run_length(16'hFFFF);
    tx_gaps_en = 1'b0;
    repeat (FULL_RUN_ITEMS) begin
      if ($urandom_range(0, 3) == 0) send_sample(random_latency());
      else send_sample(16'hFFFF);
    end
    tx_gaps_en = 1'b1;
    write_run_length(16'd1);
    send_sample(16'hFFFF);
  endtask

  task automatic test_random_runs();
    logic [15:0] len;
    int unsigned eff_len;
    int unsigned n;
    int unsigned goal;
    goal = sent_count + RANDOM_ITEMS;
    while (sent_count < goal) begin
      case ($urandom_range(0, 11))
        0:       len = 16'd0;
        1:       len = 16'hFFFF;
        2, 3:    len = 16'($urandom_range(13, 80));
        default: len = 16'($urandom_range(1, 12));
      endcase
      // now and then drop the length to or below what the open run already holds
      if (acc_taken > 1 && $urandom_range(0, 3) == 0) len = 16'($urandom_range(1, acc_taken));
      write_run_length(len);
      tx_gaps_en  = ($urandom_range(0, 3) != 0);
      rx_stall_en = ($urandom_range(0, 3) != 0);
      eff_len = (len == '0) ? 1 : len;
      n = $urandom_range(1, (eff_len > 70) ? 150 : 2 * eff_len + 1);
      repeat (n) send_sample(random_latency());
    end
    tx_gaps_en  = 1'b1;
    rx_stall_en = 1'b1;
  endtask

  // receiver holds off while the sender keeps going, so the input side backs up
  task automatic test_output_backpressure();
    write_run_length(16'd3);
    tx_gaps_en = 1'b0;
    hold_req++;
    repeat (90) send_sample(random_latency());
    tx_gaps_en = 1'b1;
    settle();
  endtask

  // receiver: fixed hold-off on request, otherwise always ready with stalls off, else a random on/off ready pattern
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen   <= hold_req;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (!rx_stall_en) begin
      out_ready_i <= 1'b1;
    end else if (phase_left != 0) begin
      phase_left <= phase_left - 1;
    end else begin
      out_ready_i <= !out_ready_i;
      phase_left  <= out_ready_i ? $urandom_range(0, 11) : $urandom_range(0, 24);
    end
  end

  // each accepted result against the oldest prediction
  always @(posedge clk_i) begin : check_results
    run_stats_t want;
    run_stats_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {min_value_o, max_value_o, mean_value_o, std_dev_o};
      if (pending_stats.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: min %0d max %0d mean %0d sd %0d",
                                  got.min_value, got.max_value, got.mean_value, got.std_dev));
      end else begin
        want = pending_stats.pop_front();
        if (got.min_value !== want.min_value || got.max_value !== want.max_value ||
            got.mean_value !== want.mean_value || got.std_dev !== want.std_dev) begin
          report_mismatch($sformatf(
            "expected min %0d max %0d mean %0d sd %0d, got min %0d max %0d mean %0d sd %0d",
            want.min_value, want.max_value, want.mean_value, want.std_dev,
            got.min_value, got.max_value, got.mean_value, got.std_dev));
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_run_length();
    test_zero_run_length();
    test_unit_run_length();
    test_extreme_samples();
    test_full_length_run();
    test_random_runs();
    test_output_backpressure();
    settle();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sample_statistics_engine_core.f =====
hw/rtl/sse_pkg.sv
hw/rtl/sample_statistics_engine_core.sv
tb/testbench.sv
